>>> design/tfbp_pkg.sv
// shared constants, operation codes and control structs of the tiled fill blit planner
// no dependencies; used by tfbp_alu, tfbp_out and tiled_fill_blit_planner_core
`default_nettype none

package tfbp_pkg;

    // default coordinate field width
    localparam int COORD_BITS_DEF = 15;

    // copy commands kept per request, later ones are dropped
    localparam int MAX_CMDS = 34;
    localparam int CNT_W    = $clog2(MAX_CMDS + 1);

    // shared unit operation codes
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd0;  // a + b
    localparam logic [OP_W-1:0] OP_SUB   = 3'd1;  // a - b
    localparam logic [OP_W-1:0] OP_SUBP1 = 3'd2;  // a - b + 1
    localparam logic [OP_W-1:0] OP_MIN   = 3'd3;  // min(a, b)
    localparam logic [OP_W-1:0] OP_MINZ  = 3'd4;  // max(min(a, b), 0)

    // sequencer requests to the output stage
    typedef struct packed {
        logic push;   // new command into the hold slot
        logic flush;  // end of request, send held command as last
    } t_out_ctl;

    // output stage status back to the sequencer
    typedef struct packed {
        logic stall;       // request cannot be taken this cycle
        logic hold_valid;  // a command waits in the hold slot
    } t_out_sts;

endpackage

`default_nettype wire

>>> design/tfbp_alu.sv
// shared add / subtract / minimum unit of the tiled fill blit planner
// depends on tfbp_pkg for operation codes; operands are two's complement
`default_nettype none

module tfbp_alu #(
    parameter int W = tfbp_pkg::COORD_BITS_DEF + 4
) (
    input  wire logic [tfbp_pkg::OP_W-1:0] i_op,
    input  wire logic [W-1:0]              i_a,
    input  wire logic [W-1:0]              i_b,
    output logic      [W-1:0]              o_res
);

    logic [W-1:0] bb;
    logic [1:0]   cin;
    logic [W-1:0] sum;
    logic [W-1:0] pick;

    // one adder, the compare for min comes from its sign
    always_comb begin
        case (i_op)
            tfbp_pkg::OP_ADD: begin
                bb  = i_b;
                cin = 2'd0;
            end
            tfbp_pkg::OP_SUBP1: begin
                bb  = ~i_b;
                cin = 2'd2;
            end
            default: begin
                bb  = ~i_b;
                cin = 2'd1;
            end
        endcase
        sum  = i_a + bb + W'(cin);
        pick = sum[W-1] ? i_a : i_b;
        case (i_op)
            tfbp_pkg::OP_MIN:  o_res = pick;
            tfbp_pkg::OP_MINZ: o_res = pick[W-1] ? '0 : pick;
            default:           o_res = sum;
        endcase
    end

endmodule

`default_nettype wire

>>> design/tfbp_out.sv
// hold slot and output register of the tiled fill blit planner
// depends on tfbp_pkg for the control and status structs
`default_nettype none

module tfbp_out #(
    parameter int DATA_W = 96
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tfbp_pkg::t_out_ctl i_ctl,
    input  wire logic [DATA_W-1:0]  i_data,
    input  wire logic               i_user,
    output tfbp_pkg::t_out_sts      o_sts,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [DATA_W-1:0]       o_m_tdata,
    output logic                    o_m_tuser,
    output logic                    o_m_tlast
);

    logic              r_hold_valid;
    logic [DATA_W-1:0] r_hold_data;
    logic              r_hold_user;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_user;
    logic              r_out_last;

    logic out_free;
    logic req;
    logic stall;
    logic move;

    // a held command leaves only when the next one or the end is known
    assign out_free = !r_out_valid || i_m_tready;
    assign req      = i_ctl.push || i_ctl.flush;
    assign stall    = r_hold_valid && req && !out_free;
    assign move     = r_hold_valid && req && out_free;

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctl.push && !stall) begin
                r_hold_valid <= 1'b1;
            end else if (i_ctl.flush && !stall) begin
                r_hold_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !stall) begin
            r_hold_data <= i_data;
            r_hold_user <= i_user;
        end
        if (move) begin
            r_out_data <= r_hold_data;
            r_out_user <= r_hold_user;
            r_out_last <= i_ctl.flush;
        end
    end

    assign o_sts.stall      = stall;
    assign o_sts.hold_valid = r_hold_valid;
    assign o_m_tvalid       = r_out_valid;
    assign o_m_tdata        = r_out_data;
    assign o_m_tuser        = r_out_user;
    assign o_m_tlast        = r_out_last;

endmodule

`default_nettype wire

>>> design/tiled_fill_blit_planner_core.sv
// tiled fill blit planner: sequencer and request registers around one shared unit
// depends on tfbp_pkg, tfbp_alu and tfbp_out
`default_nettype none

// One fill request (tile offset, tile size, inclusive destination rectangle) turns
// into an ordered list of up to 34 rectangle copy commands: up to four pieces of the
// wrapped tile from the source, then a row fill from the destination's own top-left
// with doubling widths, then a column fill with doubling heights over the full width.
// The last command of a request carries tlast; a request that yields nothing gives no
// transfer. All address arithmetic goes through one adder/min unit, one operation per
// cycle while the output side does not stall; the input is ready only between requests.
// Results wait in a hold slot and an output register, so the next request may start
// while the final command is still being taken.
module tiled_fill_blit_planner_core #(
    parameter int COORD_BITS = tfbp_pkg::COORD_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tile_offset_x, tile_offset_y, tile_width, tile_height,
    // rect_left, rect_top, rect_right, rect_bottom, zero fill
    input  wire logic [((8*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // copy_src_x, copy_src_y, copy_dst_x, copy_dst_y, copy_width, copy_height, zero fill
    output logic [((6*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // from_target
    output logic [0:0]                  m_axis_tuser,
    // last_copy
    output logic                        m_axis_tlast
);

    localparam int CB    = COORD_BITS;
    localparam int W     = COORD_BITS + 4;
    localparam int OUT_W = ((6*COORD_BITS+7)/8)*8;
    localparam int ST_W  = 5;

    localparam logic [ST_W-1:0] ST_IDLE = 5'd0;
    localparam logic [ST_W-1:0] ST_RW   = 5'd1;
    localparam logic [ST_W-1:0] ST_RH   = 5'd2;
    localparam logic [ST_W-1:0] ST_W1A  = 5'd3;
    localparam logic [ST_W-1:0] ST_W1B  = 5'd4;
    localparam logic [ST_W-1:0] ST_X2   = 5'd5;
    localparam logic [ST_W-1:0] ST_W2A  = 5'd6;
    localparam logic [ST_W-1:0] ST_W2B  = 5'd7;
    localparam logic [ST_W-1:0] ST_H1A  = 5'd8;
    localparam logic [ST_W-1:0] ST_H1B  = 5'd9;
    localparam logic [ST_W-1:0] ST_Y2   = 5'd10;
    localparam logic [ST_W-1:0] ST_H2A  = 5'd11;
    localparam logic [ST_W-1:0] ST_H2B  = 5'd12;
    localparam logic [ST_W-1:0] ST_HB   = 5'd13;
    localparam logic [ST_W-1:0] ST_P0   = 5'd14;
    localparam logic [ST_W-1:0] ST_P1   = 5'd15;
    localparam logic [ST_W-1:0] ST_P2   = 5'd16;
    localparam logic [ST_W-1:0] ST_P3   = 5'd17;
    localparam logic [ST_W-1:0] ST_R0   = 5'd18;
    localparam logic [ST_W-1:0] ST_RT   = 5'd19;
    localparam logic [ST_W-1:0] ST_RS   = 5'd20;
    localparam logic [ST_W-1:0] ST_RE   = 5'd21;
    localparam logic [ST_W-1:0] ST_C0   = 5'd22;
    localparam logic [ST_W-1:0] ST_CT   = 5'd23;
    localparam logic [ST_W-1:0] ST_CS   = 5'd24;
    localparam logic [ST_W-1:0] ST_CE   = 5'd25;
    localparam logic [ST_W-1:0] ST_DONE = 5'd26;

    // strictly positive two's complement value
    function automatic logic f_pos(input logic [W-1:0] v);
        return !v[W-1] && (v != '0);
    endfunction

    // zero extend an input field
    function automatic logic [W-1:0] f_ext(input logic [CB-1:0] v);
        return {{(W-CB){1'b0}}, v};
    endfunction

    // clamp a positive size to the field range
    function automatic logic [CB-1:0] f_sat(input logic [W-1:0] v);
        return (|v[W-2:CB]) ? {CB{1'b1}} : v[CB-1:0];
    endfunction

    logic [ST_W-1:0]           r_state, n_state;
    logic [tfbp_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0] r_offx, n_offx, r_offy, n_offy, r_tw, n_tw, r_th, n_th;
    logic [W-1:0] r_left, n_left, r_top, n_top, r_right, n_right, r_bottom, n_bottom;
    logic [W-1:0] r_rw, n_rw, r_rh, n_rh, r_tmp, n_tmp, r_hb, n_hb;
    logic [W-1:0] r_w1, n_w1, r_h1, n_h1, r_w2, n_w2, r_h2, n_h2;
    logic [W-1:0] r_x2, n_x2, r_y2, n_y2, r_pos, n_pos, r_size, n_size;
    logic         r_first, n_first;

    logic [tfbp_pkg::OP_W-1:0] alu_op;
    logic [W-1:0]              alu_a, alu_b, alu_res;

    logic         c_emit, c_from;
    logic [W-1:0] c_sx, c_sy, c_dx, c_dy, c_w, c_h;
    logic [OUT_W-1:0] c_data;

    tfbp_pkg::t_out_ctl ctl;
    tfbp_pkg::t_out_sts sts;

    // shared arithmetic unit
    tfbp_alu #(
        .W (W)
    ) u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // sequencer: at most one shared-unit operation per state
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_offx   = r_offx;
        n_offy   = r_offy;
        n_tw     = r_tw;
        n_th     = r_th;
        n_left   = r_left;
        n_top    = r_top;
        n_right  = r_right;
        n_bottom = r_bottom;
        n_rw     = r_rw;
        n_rh     = r_rh;
        n_tmp    = r_tmp;
        n_hb     = r_hb;
        n_w1     = r_w1;
        n_h1     = r_h1;
        n_w2     = r_w2;
        n_h2     = r_h2;
        n_x2     = r_x2;
        n_y2     = r_y2;
        n_pos    = r_pos;
        n_size   = r_size;
        n_first  = r_first;
        alu_op   = tfbp_pkg::OP_ADD;
        alu_a    = r_pos;
        alu_b    = r_size;
        c_emit   = 1'b0;
        c_from   = 1'b0;
        c_sx     = '0;
        c_sy     = '0;
        c_dx     = '0;
        c_dy     = '0;
        c_w      = '0;
        c_h      = '0;
        ctl.flush = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_offx   = f_ext(s_axis_tdata[0*CB +: CB]);
                    n_offy   = f_ext(s_axis_tdata[1*CB +: CB]);
                    n_tw     = f_ext(s_axis_tdata[2*CB +: CB]);
                    n_th     = f_ext(s_axis_tdata[3*CB +: CB]);
                    n_left   = f_ext(s_axis_tdata[4*CB +: CB]);
                    n_top    = f_ext(s_axis_tdata[5*CB +: CB]);
                    n_right  = f_ext(s_axis_tdata[6*CB +: CB]);
                    n_bottom = f_ext(s_axis_tdata[7*CB +: CB]);
                    n_cnt    = '0;
                    n_state  = ST_RW;
                end
            end
            // rectangle size
            ST_RW: begin
                alu_op = tfbp_pkg::OP_SUBP1; alu_a = r_right; alu_b = r_left;
                n_rw = alu_res; n_state = ST_RH;
            end
            ST_RH: begin
                alu_op = tfbp_pkg::OP_SUBP1; alu_a = r_bottom; alu_b = r_top;
                n_rh = alu_res; n_state = ST_W1A;
            end
            // horizontal split of the wrapped tile
            ST_W1A: begin
                alu_op = tfbp_pkg::OP_SUB; alu_a = r_tw; alu_b = r_offx;
                n_tmp = alu_res; n_state = ST_W1B;
            end
            ST_W1B: begin
                alu_op = tfbp_pkg::OP_MINZ; alu_a = r_tmp; alu_b = r_rw;
                n_w1 = alu_res; n_state = ST_X2;
            end
            ST_X2: begin
                alu_op = tfbp_pkg::OP_ADD; alu_a = r_left; alu_b = r_w1;
                n_x2 = alu_res; n_state = ST_W2A;
            end
            ST_W2A: begin
                alu_op = tfbp_pkg::OP_SUBP1; alu_a = r_right; alu_b = r_x2;
                n_tmp = alu_res; n_state = ST_W2B;
            end
            ST_W2B: begin
                alu_op = tfbp_pkg::OP_MIN; alu_a = r_offx; alu_b = r_tmp;
                n_w2 = alu_res; n_state = ST_H1A;
            end
            // vertical split of the wrapped tile
            ST_H1A: begin
                alu_op = tfbp_pkg::OP_SUB; alu_a = r_th; alu_b = r_offy;
                n_tmp = alu_res; n_state = ST_H1B;
            end
            ST_H1B: begin
                alu_op = tfbp_pkg::OP_MINZ; alu_a = r_tmp; alu_b = r_rh;
                n_h1 = alu_res; n_state = ST_Y2;
            end
            ST_Y2: begin
                alu_op = tfbp_pkg::OP_ADD; alu_a = r_top; alu_b = r_h1;
                n_y2 = alu_res; n_state = ST_H2A;
            end
            ST_H2A: begin
                alu_op = tfbp_pkg::OP_SUBP1; alu_a = r_bottom; alu_b = r_y2;
                n_tmp = alu_res; n_state = ST_H2B;
            end
            ST_H2B: begin
                alu_op = tfbp_pkg::OP_MIN; alu_a = r_offy; alu_b = r_tmp;
                n_h2 = alu_res; n_state = ST_HB;
            end
            // height of the top band
            ST_HB: begin
                alu_op = tfbp_pkg::OP_MIN; alu_a = r_th; alu_b = r_rh;
                n_hb = alu_res; n_state = ST_P0;
            end
            // the four wrapped tile pieces
            ST_P0: begin
                c_emit = 1'b1;
                c_sx = r_offx; c_sy = r_offy; c_dx = r_left; c_dy = r_top;
                c_w = r_w1; c_h = r_h1;
                n_state = ST_P1;
            end
            ST_P1: begin
                c_emit = 1'b1;
                c_sx = '0; c_sy = r_offy; c_dx = r_x2; c_dy = r_top;
                c_w = r_w2; c_h = r_h1;
                n_state = ST_P2;
            end
            ST_P2: begin
                c_emit = 1'b1;
                c_sx = r_offx; c_sy = '0; c_dx = r_left; c_dy = r_y2;
                c_w = r_w1; c_h = r_h2;
                n_state = ST_P3;
            end
            ST_P3: begin
                c_emit = 1'b1;
                c_sx = '0; c_sy = '0; c_dx = r_x2; c_dy = r_y2;
                c_w = r_w2; c_h = r_h2;
                n_state = ST_R0;
            end
            // row fill with doubling widths
            ST_R0: begin
                alu_op = tfbp_pkg::OP_ADD; alu_a = r_left; alu_b = r_tw;
                n_pos = alu_res; n_first = 1'b1; n_state = ST_RT;
            end
            ST_RT: begin
                alu_op = tfbp_pkg::OP_SUBP1; alu_a = r_right; alu_b = r_pos;
                n_tmp = alu_res; n_state = ST_RS;
            end
            ST_RS: begin
                alu_op = tfbp_pkg::OP_MIN;
                alu_a  = r_first ? r_tw : {r_size[W-2:0], 1'b0};
                alu_b  = r_tmp;
                n_size = alu_res; n_first = 1'b0; n_state = ST_RE;
            end
            ST_RE: begin
                if (f_pos(r_tmp) && f_pos(r_size)) begin
                    c_emit = 1'b1; c_from = 1'b1;
                    c_sx = r_left; c_sy = r_top; c_dx = r_pos; c_dy = r_top;
                    c_w = r_size; c_h = r_hb;
                    alu_op = tfbp_pkg::OP_ADD; alu_a = r_pos; alu_b = r_size;
                    n_pos = alu_res; n_state = ST_RT;
                end else begin
                    n_state = ST_C0;
                end
            end
            // column fill with doubling heights
            ST_C0: begin
                alu_op = tfbp_pkg::OP_ADD; alu_a = r_top; alu_b = r_th;
                n_pos = alu_res; n_first = 1'b1; n_state = ST_CT;
            end
            ST_CT: begin
                alu_op = tfbp_pkg::OP_SUBP1; alu_a = r_bottom; alu_b = r_pos;
                n_tmp = alu_res; n_state = ST_CS;
            end
            ST_CS: begin
                alu_op = tfbp_pkg::OP_MIN;
                alu_a  = r_first ? r_th : {r_size[W-2:0], 1'b0};
                alu_b  = r_tmp;
                n_size = alu_res; n_first = 1'b0; n_state = ST_CE;
            end
            ST_CE: begin
                if (f_pos(r_tmp) && f_pos(r_size)) begin
                    c_emit = 1'b1; c_from = 1'b1;
                    c_sx = r_left; c_sy = r_top; c_dx = r_left; c_dy = r_pos;
                    c_w = r_rw; c_h = r_size;
                    alu_op = tfbp_pkg::OP_ADD; alu_a = r_pos; alu_b = r_size;
                    n_pos = alu_res; n_state = ST_CT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            // send the held command as last
            ST_DONE: begin
                ctl.flush = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // empty pieces and commands over the limit are dropped
        ctl.push = c_emit && f_pos(c_w) && f_pos(c_h)
                   && (r_cnt < tfbp_pkg::CNT_W'(tfbp_pkg::MAX_CMDS));
        if (ctl.push) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    // command packing, sizes clamp to the field range
    assign c_data = OUT_W'({f_sat(c_h), f_sat(c_w), c_dy[CB-1:0], c_dx[CB-1:0],
                            c_sy[CB-1:0], c_sx[CB-1:0]});

    assign s_axis_tready = (r_state == ST_IDLE);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else if (!sts.stall) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // request and working registers
    always_ff @(posedge i_clk) begin
        if (!sts.stall) begin
            r_offx   <= n_offx;
            r_offy   <= n_offy;
            r_tw     <= n_tw;
            r_th     <= n_th;
            r_left   <= n_left;
            r_top    <= n_top;
            r_right  <= n_right;
            r_bottom <= n_bottom;
            r_rw     <= n_rw;
            r_rh     <= n_rh;
            r_tmp    <= n_tmp;
            r_hb     <= n_hb;
            r_w1     <= n_w1;
            r_h1     <= n_h1;
            r_w2     <= n_w2;
            r_h2     <= n_h2;
            r_x2     <= n_x2;
            r_y2     <= n_y2;
            r_pos    <= n_pos;
            r_size   <= n_size;
            r_first  <= n_first;
        end
    end

    // hold slot and output register
    tfbp_out #(
        .DATA_W (OUT_W)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_data     (c_data),
        .i_user     (c_from),
        .o_sts      (sts),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser[0]),
        .o_m_tlast  (m_axis_tlast)
    );

    // idle means the previous request has left the hold slot
    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !sts.hold_valid)
        else $error("hold slot occupied while idle");

    // command count stays within the limit
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= tfbp_pkg::CNT_W'(tfbp_pkg::MAX_CMDS))
        else $error("command count over limit");

    // an accepted request starts the setup sequence
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == ST_RW))
        else $error("accepted request did not start setup");

    // a completed end step leaves nothing held
    a_done_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !sts.stall) |=> (r_state == ST_IDLE && !sts.hold_valid))
        else $error("request end left a held command");

endmodule

`default_nettype wire
